// ===== hdl/rcv_pkg.sv =====
// Shared types and constants for the record chain validator.
package rcv_pkg;

	// Verdict and chain status codes
	localparam logic [1:0] VERDICT_CONT   = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_STOP   = 2'd2;
	localparam logic [1:0] VERDICT_NOTFMT = 2'd3;

	// Header constants
	localparam logic [7:0]  MAGIC_0     = 8'h4C;
	localparam logic [7:0]  MAGIC_1     = 8'h4A;
	localparam logic [7:0]  TYPE_A      = 8'h1A;
	localparam logic [7:0]  TYPE_B      = 8'h0A;
	localparam logic [7:0]  PAD_BYTE    = 8'h00;
	localparam logic [31:0] HEADER_LEN  = 32'd8;
	localparam logic [32:0] HEADER_LAST = 33'd7;
	localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
	localparam logic [31:0] MAX_SIZE_RESET = 32'hFFFF_FFFF;

	// One result word passed from the step logic to the output register
	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] chain_end;
	} rcv_result_t;

endpackage

// ===== hdl/rcv_step.sv =====
// Per-file chain state and the combinational header judgement for each byte.
module rcv_step import rcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	input  logic [31:0] max_file_size,
	output rcv_result_t result
);

	logic [31:0] pos_q;
	logic [31:0] next_q;
	logic [63:0] shift_q;
	logic        first_q;
	logic [1:0]  status_q;

	logic [31:0] pos_e;
	logic [31:0] next_e;
	logic [63:0] shift_e;
	logic        first_e;
	logic [1:0]  status_e;

	logic [63:0] shift_n;
	logic [31:0] next_n;
	logic        first_n;
	logic [1:0]  status_n;
	logic [1:0]  verdict;
	logic [31:0] pos_n;

	logic        at_header;
	logic        ok;
	logic        type_ok;
	logic [31:0] len;
	logic [32:0] rec_end;
	logic        too_big;

	// A start mark clears the file state before its byte is taken.
	always_comb begin
		pos_e    = start_of_file ? 32'd0 : pos_q;
		next_e   = start_of_file ? 32'd0 : next_q;
		shift_e  = start_of_file ? 64'd0 : shift_q;
		first_e  = start_of_file ? 1'b1 : first_q;
		status_e = start_of_file ? VERDICT_CONT : status_q;
	end

	// Header fields as they stand once this byte is shifted in.
	assign shift_n   = {shift_e[55:0], data_byte};
	assign len       = shift_n[31:0];
	assign ok        = (shift_n[63:56] == MAGIC_0) && (shift_n[55:48] == MAGIC_1) &&
	                   (shift_n[39:32] == PAD_BYTE) && (len >= HEADER_LEN);
	assign type_ok   = (shift_n[47:40] == TYPE_A) || (shift_n[47:40] == TYPE_B);
	assign at_header = ({1'b0, pos_e} == ({1'b0, next_e} + HEADER_LAST));
	assign rec_end   = {1'b0, next_e} + {1'b0, len};
	assign too_big   = rec_end > {1'b0, max_file_size};
	assign pos_n     = (pos_e == POS_MAX) ? pos_e : pos_e + 32'd1;

	// Verdict and next chain state.
	always_comb begin
		next_n   = next_e;
		first_n  = first_e;
		status_n = status_e;
		verdict  = VERDICT_CONT;
		if (status_e != VERDICT_CONT) begin
			verdict = status_e;
		end else begin
			if (at_header) begin
				if (first_e && !(ok && type_ok)) begin
					status_n = VERDICT_NOTFMT;
					verdict  = VERDICT_NOTFMT;
				end else if (!ok || too_big) begin
					status_n = VERDICT_STOP;
					verdict  = VERDICT_STOP;
				end else begin
					next_n  = rec_end[31:0];
					first_n = 1'b0;
					verdict = VERDICT_ACCEPT;
				end
			end
			// The last addressable byte ends a chain still in progress.
			if ((pos_e == POS_MAX) && (status_n == VERDICT_CONT)) begin
				status_n = VERDICT_STOP;
				verdict  = VERDICT_STOP;
			end
		end
	end

	assign result.verdict   = verdict;
	assign result.chain_end = next_n;

	// State registers, updated on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 32'd0;
			next_q   <= 32'd0;
			shift_q  <= 64'd0;
			first_q  <= 1'b1;
			status_q <= VERDICT_CONT;
		end else if (accept) begin
			pos_q    <= pos_n;
			next_q   <= next_n;
			shift_q  <= shift_n;
			first_q  <= first_n;
			status_q <= status_n;
		end
	end

endmodule

// ===== hdl/rcv_out_reg.sv =====
// Output register holding one result word until the downstream side takes it.
module rcv_out_reg import rcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rcv_result_t result,
	input  logic        m_tready,
	output logic        m_tvalid,
	output rcv_result_t held,
	output logic        can_load
);

	logic        valid_q;
	rcv_result_t data_q;

	// Space is free when empty or when the held word leaves this cycle.
	assign can_load = !valid_q || m_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset needed.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign held     = data_q;

endmodule

// ===== hdl/record_chain_validator_top.sv =====
// An accepted byte's result word reaches the master side in the next cycle.
// Throughput: one byte per cycle unless m_tready stalls; the header check and the
// single end-of-record add sit between the state registers and the output register.
// Reset: arst_n clears the chain state, empties the output register and sets
// max_file_size to 0xFFFFFFFF. A start-of-file mark clears the chain state.
module record_chain_validator_top import rcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] start_of_file
	// Master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] chain_end
	output logic [1:0]  m_tuser,   // [1:0] verdict
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // [31:0] max_file_size
);

	logic [31:0] max_size_q;
	logic        accept;
	logic        can_load;
	rcv_result_t result;
	rcv_result_t held;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_SIZE_RESET;
		end else if (cfg_valid) begin
			max_size_q <= cfg_data;
		end
	end

	// Input handshake.
	assign s_tready = can_load;
	assign accept   = s_tvalid && can_load;

	rcv_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.start_of_file (s_tuser),
		.max_file_size (max_size_q),
		.result        (result)
	);

	rcv_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.result   (result),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.held     (held),
		.can_load (can_load)
	);

	// Result word onto the master side.
	assign m_tdata = held.chain_end;
	assign m_tuser = held.verdict;

endmodule
